FILE: design/aaf_pkg.sv
package aaf_pkg;

	localparam int LIST_DEPTH  = 32;
	localparam int MAX_PAYLOAD = 48;

	localparam int ADDR_W    = 48;
	localparam int IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
	localparam int CFG_IDX_W = 3;

	// request kinds
	localparam logic [1:0] REQ_ADVERT     = 2'd0;
	localparam logic [1:0] REQ_WRITE      = 2'd1;
	localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

	// verdict codes
	localparam logic [2:0] V_OK        = 3'd0;
	localparam logic [2:0] V_NOT_READY = 3'd1;
	localparam logic [2:0] V_WRONG_CMD = 3'd2;
	localparam logic [2:0] V_TOO_LONG  = 3'd3;
	localparam logic [2:0] V_EMPTY     = 3'd4;
	localparam logic [2:0] V_FILTERED  = 3'd5;
	localparam logic [2:0] V_UNSYNCED  = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LIST_SIZE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_MODE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_TIME_SYNC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RX_CONFIGURED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTINGS_READY = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic              go;
		logic [ADDR_W-1:0] key;
		logic [CNT_W-1:0]  n;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_rsp_t;

endpackage

FILE: design/aaf_ram.sv
module aaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/aaf_scan.sv
module aaf_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aaf_pkg::scan_req_t          req,
	output aaf_pkg::scan_rsp_t          rsp,
	output logic                        rd_en,
	output logic [aaf_pkg::IDX_W-1:0]   rd_addr,
	input  logic [aaf_pkg::ADDR_W-1:0]  rd_data
);
	import aaf_pkg::*;

	logic              active_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  n_q;
	logic [ADDR_W-1:0] key_q;
	logic              hit_q;
	logic              rd_s1;
	logic              last_s1;
	logic              is_last;
	logic              match;

	assign is_last = (idx_q == (n_q - CNT_W'(1)));
	assign rd_en   = active_q;
	assign rd_addr = idx_q[IDX_W-1:0];
	assign match   = (rd_data == key_q);

	assign rsp.done = rd_s1 && last_s1;
	assign rsp.hit  = hit_q || (rd_s1 && match);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			rd_s1    <= 1'b0;
			last_s1  <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			rd_s1   <= active_q;
			last_s1 <= active_q && is_last;
			if (req.go) begin
				active_q <= 1'b1;
				idx_q    <= '0;
				hit_q    <= 1'b0;
			end else begin
				if (active_q) begin
					idx_q <= idx_q + CNT_W'(1);
					if (is_last) begin
						active_q <= 1'b0;
					end
				end
				// sticky hit over the compare stage
				if (rd_s1 && match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			key_q <= req.key;
			n_q   <= req.n;
		end
	end

endmodule

FILE: design/advert_admission_filter_unit.sv
// Admission filter for received advertisements. A beat is taken when start is high and busy
// is low; every beat gives exactly one result, shown for one cycle with done high, and the
// receiver cannot hold it off. List writes, counter read-and-clear requests and adverts that
// are settled before the address check answer in the cycle after acceptance, and the next
// beat can be taken right away. An advert that reaches the address check scans the first
// min(list_size, 32) list entries, one entry per cycle, through the memory's single read port;
// busy is high over the scan and the result comes in the first cycle busy is low. The user
// writes configuration over the always-ready cfg channel only while idle; the block does not
// enforce it. The list memory is not cleared at reset; entries in use must be written first.
module advert_admission_filter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [47:0]                    station_address,
	input  logic [4:0]                     entry_slot,
	input  logic                           is_report_command,
	input  logic [7:0]                     payload_length,
	input  logic                           time_synced,
	output logic                           done,
	output logic [2:0]                     verdict,
	output logic                           restart_silence_timer,
	output logic [31:0]                    count_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [aaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import aaf_pkg::*;

	state_t state_q, state_d;

	logic [5:0]  list_size_q;
	logic        allow_mode_q;
	logic        req_sync_q;
	logic        rx_cfg_q;
	logic        set_ready_q;
	logic [31:0] cnt_q;
	logic        synced_q;

	logic        accept;
	logic        imm_done;
	logic [2:0]  imm_verdict;
	logic        imm_restart;
	logic [31:0] imm_count;
	logic        need_scan;
	logic        cnt_inc;
	logic        cnt_clr;
	logic        slot_ok;
	logic        wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [CNT_W-1:0] list_n;

	logic [2:0]  res_verdict;
	logic        res_restart;
	logic        filtered;

	scan_req_t   scan_req;
	scan_rsp_t   scan_rsp;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [ADDR_W-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q == ST_SCAN);
	assign accept    = start && !busy;

	assign slot_ok = ({27'd0, entry_slot} < 32'(LIST_DEPTH));
	assign wr_addr = IDX_W'({27'd0, entry_slot});
	assign wr_en   = accept && (req_type == REQ_WRITE) && slot_ok;
	assign list_n  = (32'(list_size_q) > 32'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH)
	                                                      : CNT_W'(list_size_q);

	// request decode and the checks that need no list access
	always_comb begin
		imm_done    = 1'b0;
		imm_verdict = V_OK;
		imm_restart = 1'b0;
		imm_count   = '0;
		need_scan   = 1'b0;
		cnt_inc     = 1'b0;
		cnt_clr     = 1'b0;
		if (accept) begin
			unique case (req_type)
				REQ_ADVERT: begin
					if (!rx_cfg_q || !set_ready_q) begin
						imm_done    = 1'b1;
						imm_verdict = V_NOT_READY;
					end else begin
						cnt_inc = 1'b1;
						if (!is_report_command) begin
							imm_done    = 1'b1;
							imm_verdict = V_WRONG_CMD;
						end else if (32'(payload_length) > 32'(MAX_PAYLOAD)) begin
							imm_done    = 1'b1;
							imm_verdict = V_TOO_LONG;
						end else if (payload_length == 8'd0) begin
							imm_done    = 1'b1;
							imm_verdict = V_EMPTY;
						end else if (list_size_q == 6'd0) begin
							imm_done    = 1'b1;
							imm_restart = 1'b1;
							imm_verdict = (req_sync_q && !time_synced) ? V_UNSYNCED : V_OK;
						end else begin
							need_scan = 1'b1;
						end
					end
				end
				REQ_READ_CLEAR: begin
					imm_done  = 1'b1;
					imm_count = cnt_q;
					cnt_clr   = 1'b1;
				end
				default: begin
					imm_done = 1'b1;
				end
			endcase
		end
	end

	assign scan_req.go  = need_scan;
	assign scan_req.key = station_address;
	assign scan_req.n   = list_n;

	// verdict after the list scan
	assign filtered    = allow_mode_q ? !scan_rsp.hit : scan_rsp.hit;
	assign res_restart = !filtered;
	assign res_verdict = filtered ? V_FILTERED :
	                     (req_sync_q && !synced_q) ? V_UNSYNCED : V_OK;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (need_scan) state_d = ST_SCAN;
			ST_SCAN: if (scan_rsp.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			cnt_q        <= '0;
			list_size_q  <= '0;
			allow_mode_q <= 1'b0;
			req_sync_q   <= 1'b0;
			rx_cfg_q     <= 1'b0;
			set_ready_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= imm_done || scan_rsp.done;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 32'd1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LIST_SIZE:      list_size_q  <= cfg_data[5:0];
					CFG_ALLOW_MODE:     allow_mode_q <= cfg_data[0];
					CFG_REQ_TIME_SYNC:  req_sync_q   <= cfg_data[0];
					CFG_RX_CONFIGURED:  rx_cfg_q     <= cfg_data[0];
					CFG_SETTINGS_READY: set_ready_q  <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (need_scan) begin
			synced_q <= time_synced;
		end
		if (scan_rsp.done) begin
			verdict               <= res_verdict;
			restart_silence_timer <= res_restart;
			count_value           <= '0;
		end else if (imm_done) begin
			verdict               <= imm_verdict;
			restart_silence_timer <= imm_restart;
			count_value           <= imm_count;
		end
	end

	aaf_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (LIST_DEPTH)
	) u_list_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (station_address),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	aaf_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (scan_req),
		.rsp     (scan_rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

FILE: design/aaf_checker.sv
module aaf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [1:0]                     req_type,
	input logic                           done,
	input logic [2:0]                     verdict,
	input logic                           restart_silence_timer,
	input logic [31:0]                    count_value,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);
	import aaf_pkg::*;

	// non-advert requests answer in the very next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type != REQ_ADVERT) |=> (done && verdict == V_OK))
		else $error("request other than advert not answered next cycle");

	// the silence timer restarts only for adverts that passed the address check
	a_restart_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && restart_silence_timer) |-> (verdict == V_OK || verdict == V_UNSYNCED))
		else $error("restart with a drop verdict");

	// a counter value comes only with a plain done verdict
	a_count_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && count_value != 32'd0) |-> (verdict == V_OK && !restart_silence_timer))
		else $error("count value with an advert verdict");

	// a scan beat never completes at once: done stays low for a scan that has just raised busy
	a_scan_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |=> !done)
		else $error("result while scan just started");

	// config is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind advert_admission_filter_unit aaf_checker u_aaf_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.start                 (start),
	.busy                  (busy),
	.req_type              (req_type),
	.done                  (done),
	.verdict               (verdict),
	.restart_silence_timer (restart_silence_timer),
	.count_value           (count_value),
	.cfg_valid             (cfg_valid),
	.cfg_ready             (cfg_ready)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import aaf_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] addr;
		logic [4:0]  slot;
		logic        report;
		logic [7:0]  length;
		logic        synced;
	} request_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic        restart;
		logic [31:0] count;
	} outcome_t;

	typedef struct packed {
		bit                   reg_write;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0]          reg_val;
		request_t             req;
		bit                   typed;
		outcome_t             want;
	} step_t;

	localparam request_t IDLE_REQ = '0;
	localparam outcome_t NO_RESULT = '0;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           req_type;
	logic [47:0]          station_address;
	logic [4:0]           entry_slot;
	logic                 is_report_command;
	logic [7:0]           payload_length;
	logic                 time_synced;
	logic                 done;
	logic [2:0]           verdict;
	logic                 restart_silence_timer;
	logic [31:0]          count_value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// mirror of the block: list contents, advert counter and settings
	logic [47:0] stations [LIST_DEPTH];
	logic [31:0] advert_count;
	logic [5:0]  list_entries;
	logic        allow_mode;
	logic        need_sync;
	logic        rx_configured;
	logic        settings_ok;

	outcome_t pending_verdicts [$];
	int       fails;

	step_t directed_steps [30] = '{
		// nothing is counted before both ready bits are set
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1, 5'd0, 1'b1, 8'd10, 1'b1},
			1'b1, '{V_NOT_READY, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_READ_CLEAR, ALL_ONES, 5'd31, 1'b0, 8'd255, 1'b0},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_UNKNOWN, ALL_ONES, 5'd31, 1'b1, 8'd255, 1'b1},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		'{1'b1, CFG_RX_CONFIGURED, 32'd1, IDLE_REQ, 1'b0, NO_RESULT},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h0, 5'd0, 1'b1, 8'd1, 1'b1},
			1'b1, '{V_NOT_READY, 1'b0, 32'd0}},
		'{1'b1, CFG_SETTINGS_READY, 32'd1, IDLE_REQ, 1'b0, NO_RESULT},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1, 5'd0, 1'b0, 8'd10, 1'b1},
			1'b1, '{V_WRONG_CMD, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1, 5'd0, 1'b1, 8'd255, 1'b1},
			1'b1, '{V_TOO_LONG, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1, 5'd0, 1'b1, 8'd49, 1'b1},
			1'b1, '{V_TOO_LONG, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1, 5'd0, 1'b1, 8'd0, 1'b1},
			1'b1, '{V_EMPTY, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1, 5'd0, 1'b1, 8'd48, 1'b0},
			1'b1, '{V_OK, 1'b1, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, ALL_ONES, 5'd31, 1'b1, 8'd1, 1'b0},
			1'b1, '{V_OK, 1'b1, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_READ_CLEAR, 48'h0, 5'd0, 1'b1, 8'd0, 1'b1},
			1'b1, '{V_OK, 1'b0, 32'd6}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_READ_CLEAR, 48'h0, 5'd0, 1'b1, 8'd0, 1'b1},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_WRITE, ALL_ONES, 5'd0, 1'b0, 8'd0, 1'b0},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_WRITE, 48'h0, 5'd1, 1'b1, 8'd255, 1'b1},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_WRITE, 48'h1234_5678_9ABC, 5'd2, 1'b1, 8'd7, 1'b0},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_WRITE, 48'h8000_0000_0001, 5'd31, 1'b0, 8'd9, 1'b1},
			1'b1, '{V_OK, 1'b0, 32'd0}},
		// deny list over the first three entries
		'{1'b1, CFG_LIST_SIZE, 32'd3, IDLE_REQ, 1'b0, NO_RESULT},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, ALL_ONES, 5'd0, 1'b1, 8'd20, 1'b1},
			1'b1, '{V_FILTERED, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h0, 5'd0, 1'b1, 8'd20, 1'b1},
			1'b1, '{V_FILTERED, 1'b0, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h5, 5'd0, 1'b1, 8'd20, 1'b1},
			1'b0, NO_RESULT},
		'{1'b1, CFG_ALLOW_MODE, 32'd1, IDLE_REQ, 1'b0, NO_RESULT},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h1234_5678_9ABC, 5'd0, 1'b1, 8'd3, 1'b0},
			1'b0, NO_RESULT},
		// slot 31 holds an address but lies outside the entries in use
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h8000_0000_0001, 5'd0, 1'b1, 8'd3, 1'b1},
			1'b0, NO_RESULT},
		'{1'b1, CFG_REQ_TIME_SYNC, 32'd1, IDLE_REQ, 1'b0, NO_RESULT},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h0, 5'd0, 1'b1, 8'd30, 1'b0},
			1'b1, '{V_UNSYNCED, 1'b1, 32'd0}},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h0, 5'd0, 1'b1, 8'd30, 1'b1},
			1'b0, NO_RESULT},
		// address check comes before the time check
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_ADVERT, 48'h7, 5'd0, 1'b1, 8'd30, 1'b0},
			1'b0, NO_RESULT},
		'{1'b0, CFG_LIST_SIZE, 32'd0, '{REQ_READ_CLEAR, ALL_ONES, 5'd3, 1'b0, 8'd1, 1'b0},
			1'b0, NO_RESULT}
	};

	advert_admission_filter_unit dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.req_type              (req_type),
		.station_address       (station_address),
		.entry_slot            (entry_slot),
		.is_report_command     (is_report_command),
		.payload_length        (payload_length),
		.time_synced           (time_synced),
		.done                  (done),
		.verdict               (verdict),
		.restart_silence_timer (restart_silence_timer),
		.count_value           (count_value),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("advert_admission_filter_unit: mismatch");
		$finish;
	end

	function automatic outcome_t judge_request(input request_t r);
		outcome_t    o;
		int unsigned in_use;
		bit          hit;
		o = '0;
		o.verdict = V_OK;
		in_use = (list_entries > LIST_DEPTH) ? LIST_DEPTH : list_entries;
		hit = 1'b0;
		case (r.kind)
			REQ_ADVERT: begin
				if (!rx_configured || !settings_ok) begin
					o.verdict = V_NOT_READY;
				end else begin
					advert_count = advert_count + 32'd1;
					for (int unsigned i = 0; i < in_use; i++)
						if (stations[i] == r.addr)
							hit = 1'b1;
					if (!r.report)
						o.verdict = V_WRONG_CMD;
					else if (r.length > MAX_PAYLOAD)
						o.verdict = V_TOO_LONG;
					else if (r.length == 8'd0)
						o.verdict = V_EMPTY;
					else if (list_entries != 6'd0 && (allow_mode ? !hit : hit))
						o.verdict = V_FILTERED;
					else begin
						o.restart = 1'b1;
						if (need_sync && !r.synced)
							o.verdict = V_UNSYNCED;
					end
				end
			end
			REQ_WRITE: begin
				stations[r.slot] = r.addr;
			end
			REQ_READ_CLEAR: begin
				o.count = advert_count;
				advert_count = '0;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic request_t random_request();
		request_t    r;
		int          pick;
		int unsigned in_use;
		r.addr = {16'($urandom), $urandom};
		r.slot = 5'($urandom_range(LIST_DEPTH - 1));
		r.report = ($urandom_range(9) != 0);
		r.length = 8'($urandom);
		r.synced = 1'($urandom_range(1));
		in_use = (list_entries > LIST_DEPTH) ? LIST_DEPTH : list_entries;
		pick = $urandom_range(99);
		if (pick < 55) begin
			r.kind = REQ_ADVERT;
			// half the adverts reuse an address held in the station list, mostly one in use
			if ($urandom_range(1)) begin
				if (in_use != 0 && $urandom_range(3) != 0)
					r.addr = stations[$urandom_range(in_use - 1)];
				else
					r.addr = stations[$urandom_range(LIST_DEPTH - 1)];
			end
			pick = $urandom_range(99);
			if (pick < 75)
				r.length = 8'($urandom_range(MAX_PAYLOAD, 1));
			else if (pick < 83)
				r.length = '0;
			else if (pick < 91)
				r.length = 8'($urandom_range(255, MAX_PAYLOAD + 1));
		end else if (pick < 80) begin
			r.kind = REQ_WRITE;
		end else if (pick < 93) begin
			r.kind = REQ_READ_CLEAR;
		end else begin
			r.kind = REQ_UNKNOWN;
		end
		return r;
	endfunction

	// holds start until the beat is taken, then records what it must give
	task automatic send(input request_t r, input bit typed, input outcome_t want);
		outcome_t predicted;
		start <= 1'b1;
		req_type <= r.kind;
		station_address <= r.addr;
		entry_slot <= r.slot;
		is_report_command <= r.report;
		payload_length <= r.length;
		time_synced <= r.synced;
		do @(posedge clk); while (busy);
		predicted = judge_request(r);
		pending_verdicts.push_back(typed ? want : predicted);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LIST_SIZE:      list_entries = val[5:0];
			CFG_ALLOW_MODE:     allow_mode = val[0];
			CFG_REQ_TIME_SYNC:  need_sync = val[0];
			CFG_RX_CONFIGURED:  rx_configured = val[0];
			CFG_SETTINGS_READY: settings_ok = val[0];
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: verdict %0d", verdict);
				fails++;
			end else begin
				w = pending_verdicts.pop_front();
				if (verdict !== w.verdict) begin
					$error("verdict: expected %0d, got %0d", w.verdict, verdict);
					fails++;
				end
				if (restart_silence_timer !== w.restart) begin
					$error("restart_silence_timer: expected %0d, got %0d", w.restart,
						restart_silence_timer);
					fails++;
				end
				if (count_value !== w.count) begin
					$error("count_value: expected %0d, got %0d", w.count, count_value);
					fails++;
				end
			end
		end
	end

	initial begin
		logic [5:0] size_extremes [6];
		logic [5:0] size;
		request_t   r;
		int         burst_left;
		int         gap;

		size_extremes = '{6'd32, 6'd63, 6'd0, 6'd1, 6'd33, 6'd31};
		fails = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ADVERT;
		station_address = '0;
		entry_slot = '0;
		is_report_command = 1'b0;
		payload_length = '0;
		time_synced = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LIST_SIZE;
		cfg_data = '0;
		advert_count = '0;
		list_entries = '0;
		allow_mode = 1'b0;
		need_sync = 1'b0;
		rx_configured = 1'b0;
		settings_ok = 1'b0;
		for (int i = 0; i < LIST_DEPTH; i++)
			stations[i] = '0;
		burst_left = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].reg_write) begin
				drain();
				write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val, 1'b1);
			end else begin
				send(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);
			end
		end

		// fill every slot so no scan ever reads an entry that was never written
		for (int s = 0; s < LIST_DEPTH; s++) begin
			r = random_request();
			r.kind = REQ_WRITE;
			r.slot = 5'(s);
			send(r, 1'b0, NO_RESULT);
		end

		for (int p = 0; p < 12; p++) begin
			drain();
			size = (p < 6) ? size_extremes[p] : 6'($urandom_range(63));
			write_reg(CFG_LIST_SIZE, 32'(size), 1'b0);
			write_reg(CFG_ALLOW_MODE, 32'($urandom_range(1)), 1'b0);
			write_reg(CFG_REQ_TIME_SYNC, (p == 0) ? 32'd1 : 32'($urandom_range(1)), 1'b0);
			write_reg(CFG_RX_CONFIGURED, (p == 2) ? 32'd0 : 32'($urandom_range(9) != 0),
				1'b0);
			write_reg(CFG_SETTINGS_READY, (p == 3) ? 32'd0 : 32'($urandom_range(9) != 0),
				1'b1);
			for (int k = 0; k < 105; k++) begin
				if (burst_left == 0) begin
					if ($urandom_range(19) == 0) begin
						drain();
					end else begin
						gap = ($urandom_range(3) == 0) ? $urandom_range(40, 1)
							: $urandom_range(8);
						if (gap != 0)
							pause(gap);
					end
					burst_left = $urandom_range(30, 1);
				end
				burst_left--;
				send(random_request(), 1'b0, NO_RESULT);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (fails == 0 && pending_verdicts.size() == 0)
			$display("advert_admission_filter_unit: match");
		else
			$display("advert_admission_filter_unit: mismatch");
		$finish;
	end

endmodule
